// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int VALUE_WIDTH  = 16;  // default arithmetic width
  localparam int MSG_WIDTH    = 16;
  localparam int RESULT_WIDTH = 16;
  localparam int DATA_WIDTH   = 32;  // register port data
  localparam int ADDR_WIDTH   = 4;   // byte address, three word registers

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

  // Operation run by the serial modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,  // base = message mod n
    OP_SQUARE,  // acc = acc * acc mod n
    OP_MULT     // acc = acc * base mod n
  } mexp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_SQR_GO,
    S_SQR,
    S_SQR_END,
    S_MUL,
    S_MUL_END
  } mexp_state_t;

  typedef struct packed {
    logic     load;         // capture request, select exponent, acc = 1
    logic     mul_start;    // clear partial result, load multiplier bits
    mexp_op_t op;
    logic     mul_step;     // one multiplier bit
    logic     exp_advance;  // move to next exponent bit
    logic     emit;         // load result register
  } mexp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_bit;
    logic exp_last;
    logic exp_zero;
  } mexp_status_t;

endpackage

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, exponent shifter and bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mexp_pkg::mexp_cmd_t               cmd,
  output mexp_pkg::mexp_status_t            status,
  input  logic [VALUE_WIDTH-1:0]            modulus,
  input  logic [VALUE_WIDTH-1:0]            public_exponent,
  input  logic [VALUE_WIDTH-1:0]            private_exponent,
  input  logic [mexp_pkg::MSG_WIDTH-1:0]    message,
  input  logic                              mode,
  output logic [mexp_pkg::RESULT_WIDTH-1:0] result
);

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] CNT_MAX = CW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] base;
  logic [VALUE_WIDTH-1:0] exp_sh;
  logic [CW-1:0]          ecnt;
  logic [VALUE_WIDTH-1:0] r;
  logic [VALUE_WIDTH-1:0] r_next;
  logic [VALUE_WIDTH-1:0] mb;
  logic [CW-1:0]          mcnt;
  mexp_pkg::mexp_op_t     op_q;

  logic [VALUE_WIDTH-1:0] a_sel;
  logic [VALUE_WIDTH+1:0] s;
  logic [VALUE_WIDTH+1:0] n1;
  logic [VALUE_WIDTH+1:0] n2;

  // Horner step: r = (2r + bit*a) mod n, with r, a below n so s < 3n.
  // Zero modulus means plain wrap at the word width.
  always_comb begin
    case (op_q)
      mexp_pkg::OP_REDUCE: a_sel = VALUE_WIDTH'(1);
      mexp_pkg::OP_SQUARE: a_sel = acc;
      default:             a_sel = base;
    endcase
    s  = (VALUE_WIDTH+2)'({r, 1'b0}) +
         (VALUE_WIDTH+2)'(a_sel & {VALUE_WIDTH{mb[VALUE_WIDTH-1]}});
    n1 = (VALUE_WIDTH+2)'(modulus);
    n2 = (VALUE_WIDTH+2)'({modulus, 1'b0});
    if (modulus == '0) begin
      r_next = s[VALUE_WIDTH-1:0];
    end else if (s >= n2) begin
      r_next = VALUE_WIDTH'(s - n2);
    end else if (s >= n1) begin
      r_next = VALUE_WIDTH'(s - n1);
    end else begin
      r_next = s[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base   <= VALUE_WIDTH'(message);
      acc    <= VALUE_WIDTH'(1);
      exp_sh <= mode ? private_exponent : public_exponent;
      ecnt   <= CNT_MAX;
    end
    if (cmd.mul_start) begin
      op_q <= cmd.op;
      r    <= '0;
      mb   <= (cmd.op == mexp_pkg::OP_REDUCE) ? base : acc;
      mcnt <= CNT_MAX;
    end
    if (cmd.mul_step) begin
      r    <= r_next;
      mb   <= {mb[VALUE_WIDTH-2:0], 1'b0};
      mcnt <= mcnt - 1'b1;
      if (mcnt == '0) begin
        if (op_q == mexp_pkg::OP_REDUCE) begin
          base <= r_next;
        end else begin
          acc <= r_next;
        end
      end
    end
    if (cmd.exp_advance) begin
      exp_sh <= {exp_sh[VALUE_WIDTH-2:0], 1'b0};
      ecnt   <= ecnt - 1'b1;
    end
    if (cmd.emit) begin
      result <= mexp_pkg::RESULT_WIDTH'(acc);
    end
  end

  always_comb begin
    status.mul_last = (mcnt == '0);
    status.exp_bit  = exp_sh[VALUE_WIDTH-1];
    status.exp_last = (ecnt == '0);
    status.exp_zero = (exp_sh == '0);
  end

  // a fresh multiplication always starts from the top bit
  a_mul_start_count: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> mcnt == CNT_MAX)
    else $error("multiplier bit count not reloaded");

endmodule

// ===== rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply and the output handshake.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mexp_pkg::mexp_cmd_t    cmd,
  input  mexp_pkg::mexp_status_t status
);

  mexp_pkg::mexp_state_t state;
  mexp_pkg::mexp_state_t state_next;
  logic                  out_valid_next;
  logic                  done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mexp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.op          = mexp_pkg::OP_SQUARE;
    done            = 1'b0;
    in_stall        = 1'b1;
    unique case (state)
      mexp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mexp_pkg::S_CHECK;
        end
      end
      mexp_pkg::S_CHECK: begin
        if (status.exp_zero) begin
          done = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = mexp_pkg::OP_REDUCE;
          state_next    = mexp_pkg::S_RED;
        end
      end
      mexp_pkg::S_RED: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = mexp_pkg::S_SQR_GO;
      end
      mexp_pkg::S_SQR_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = mexp_pkg::S_SQR;
      end
      mexp_pkg::S_SQR: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = mexp_pkg::S_SQR_END;
      end
      mexp_pkg::S_SQR_END: begin
        if (status.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.op        = mexp_pkg::OP_MULT;
          state_next    = mexp_pkg::S_MUL;
        end else begin
          cmd.exp_advance = 1'b1;
          if (status.exp_last) begin
            done = 1'b1;
          end else begin
            cmd.mul_start = 1'b1;
            state_next    = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = mexp_pkg::S_MUL_END;
      end
      mexp_pkg::S_MUL_END: begin
        cmd.exp_advance = 1'b1;
        if (status.exp_last) begin
          done = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = mexp_pkg::S_SQR;
        end
      end
      default: state_next = mexp_pkg::S_IDLE;
    endcase

    // finished: hold here until the result register is free
    if (done) begin
      if (!out_valid || !out_stall) begin
        cmd.emit   = 1'b1;
        state_next = mexp_pkg::S_IDLE;
      end else begin
        // exponent bit count stays put while waiting
        cmd.exp_advance = 1'b0;
        state_next      = state;
      end
    end

    out_valid_next = cmd.emit | (out_valid & out_stall);
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result loaded but not offered");

  a_start_step_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.mul_step))
    else $error("multiplier started and stepped together");

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// RSA-style modular exponentiation: message ^ exponent mod modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Registers (APB, byte addresses 0x0/0x4/0x8): modulus, public exponent,
//   private exponent, VALUE_WIDTH bits each. Write them only while idle.
//   Input channel: message and mode (0 public, 1 private exponent), taken on
//   in_valid with in_stall low. One request is worked on at a time.
//   Output channel: result, held in a register until out_valid meets
//   out_stall low. A new request is accepted while a result still waits.
// Operation:
//   one modular multiplication in the bit-serial unit is a start step
//   followed by one step per multiplier bit. A nonzero exponent first
//   reduces the message, then squares for every exponent bit and
//   multiplies for every set bit, from the top bit down. A zero exponent
//   gives 1 without running the multiplier.
// Modulus zero wraps at 2^W; exponent zero returns 1 unreduced.
// Reset (rst, synchronous): registers back to modulus 2, exponents 1,
// sequencer idle, no result pending. A stalled output holds its value and
// a finished request waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int VALUE_WIDTH = mexp_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mexp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [mexp_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mexp_pkg::MSG_WIDTH-1:0]    message,
  input  logic                              mode,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mexp_pkg::RESULT_WIDTH-1:0] result
);

  logic [VALUE_WIDTH-1:0] modulus;
  logic [VALUE_WIDTH-1:0] public_exponent;
  logic [VALUE_WIDTH-1:0] private_exponent;
  logic                   reg_wr;
  logic [1:0]             reg_idx;

  mexp_pkg::mexp_cmd_t    cmd;
  mexp_pkg::mexp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  // register file; writes beyond the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= VALUE_WIDTH'(2);
      public_exponent  <= VALUE_WIDTH'(1);
      private_exponent <= VALUE_WIDTH'(1);
    end else if (reg_wr) begin
      unique case (reg_idx)
        mexp_pkg::REG_MODULUS:     modulus          <= VALUE_WIDTH'(pwdata);
        mexp_pkg::REG_PUBLIC_EXP:  public_exponent  <= VALUE_WIDTH'(pwdata);
        mexp_pkg::REG_PRIVATE_EXP: private_exponent <= VALUE_WIDTH'(pwdata);
        default: ;
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    unique case (reg_idx)
      mexp_pkg::REG_MODULUS:     prdata = mexp_pkg::DATA_WIDTH'(modulus);
      mexp_pkg::REG_PUBLIC_EXP:  prdata = mexp_pkg::DATA_WIDTH'(public_exponent);
      mexp_pkg::REG_PRIVATE_EXP: prdata = mexp_pkg::DATA_WIDTH'(private_exponent);
      default:                   prdata = '0;
    endcase
  end

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mexp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .modulus          (modulus),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .message          (message),
    .mode             (mode),
    .result           (result)
  );

endmodule
